// File: rtl/stfl_pkg.sv
// shared types and constants for the sorted time table floor lookup
// no dependencies; used by stfl_key_form and sorted_time_table_floor_lookup_core
`default_nettype none

package stfl_pkg;

	// table defaults, handed to the top level parameters
	localparam int DEF_TABLE_DEPTH = 128;
	localparam int DEF_TAG_BITS    = 16;

	// fixed port widths
	localparam int OUT_TAG_BITS   = 16;
	localparam int OUT_COUNT_BITS = 8;

	// time key: exact accumulator and saturated result
	localparam int KEY_BITS  = 37;
	localparam int KACC_BITS = 42;

	// mixed radix of the time key
	localparam int YEAR_BASE    = 1900;
	localparam int DAY_RADIX    = 366;
	localparam int MONTH_RADIX  = 12;
	localparam int HOUR_RADIX   = 31;
	localparam int MINUTE_RADIX = 60;
	localparam int SECOND_RADIX = 60;

	// time fields of one transfer
	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} stfl_time_t;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_FIND   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NOP    = 2'd3
	} stfl_op_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NOT_FOUND = 2'd1,
		STS_FULL      = 2'd2
	} stfl_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY,
		ST_SCAN,
		ST_HEAD,
		ST_FIN
	} stfl_state_t;

endpackage

`default_nettype wire

// File: rtl/stfl_key_form.sv
// time key former: folds the time fields into one saturated mixed-radix key
// one multiply-add per cycle, then a saturation step; uses stfl_pkg
`default_nettype none

module stfl_key_form (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  stfl_pkg::stfl_time_t             tm,
	output logic                             done,
	output logic [stfl_pkg::KEY_BITS-1:0]    key
);

	localparam int KB = stfl_pkg::KEY_BITS;
	localparam int AB = stfl_pkg::KACC_BITS;
	localparam logic [2:0] LAST_STEP = 3'd5;

	logic                 busy_q;
	logic [2:0]           step_q;
	logic                 done_q;
	stfl_pkg::stfl_time_t tm_q;
	logic signed [AB-1:0] acc_q;
	logic [KB-1:0]        key_q;

	logic signed [AB-1:0] src;
	logic signed [AB-1:0] nxt;
	logic [8:0]           mul;
	logic signed [6:0]    add;
	logic                 acc_neg;
	logic                 acc_over;
	logic [KB-1:0]        key_sat;

	// operand selection for the current radix step
	always_comb begin
		src = acc_q;
		unique case (step_q)
			3'd0: begin
				src = $signed({{(AB-12){1'b0}}, tm_q.year})
					- $signed(AB'(stfl_pkg::YEAR_BASE));
				mul = 9'(stfl_pkg::DAY_RADIX);
				add = $signed({3'b0, tm_q.month}) - 7'sd1;
			end
			3'd1: begin
				mul = 9'(stfl_pkg::MONTH_RADIX);
				add = $signed({2'b0, tm_q.day});
			end
			3'd2: begin
				mul = 9'(stfl_pkg::HOUR_RADIX);
				add = $signed({2'b0, tm_q.hour});
			end
			3'd3: begin
				mul = 9'(stfl_pkg::MINUTE_RADIX);
				add = $signed({1'b0, tm_q.minute});
			end
			default: begin
				mul = 9'(stfl_pkg::SECOND_RADIX);
				add = $signed({1'b0, tm_q.second});
			end
		endcase
		nxt = src * $signed({1'b0, mul}) + add;
	end

	// clamp into the key range
	always_comb begin
		acc_neg  = acc_q[AB-1];
		acc_over = |acc_q[AB-2:KB];
		if (acc_neg) begin
			key_sat = '0;
		end else if (acc_over) begin
			key_sat = '1;
		end else begin
			key_sat = acc_q[KB-1:0];
		end
	end

	// step sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 3'd1;
				end
			end
		end
	end

	// accumulator and key
	always_ff @(posedge clk) begin
		if (start) begin
			tm_q <= tm;
		end
		if (busy_q && !start) begin
			if (step_q == LAST_STEP) begin
				key_q <= key_sat;
			end else begin
				acc_q <= nxt;
			end
		end
	end

	assign done = done_q;
	assign key  = key_q;

endmodule

`default_nettype wire

// File: rtl/sorted_time_table_floor_lookup_core.sv
// sorted time table with floor lookup: top level, table memory and control
// depends on stfl_pkg and stfl_key_form
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  input   | in_valid, in_stall, opcode, year .. entry_tag   | in
//  output  | out_valid, out_stall, status, match_tag,        | out
//          | entry_count                                     |
//
// insert and find run the key former, start the walk, then make one table read
// per entry walking down from the top through the single read port, plus
// wrap-up; the walk stops at the first entry at or below the key. clear, no-op
// and a refused insert go straight from idle to wrap-up. one transfer is
// worked on at a time.
// reset empties the table at once; entries are not cleared.
// a result sits in an output register, so the next transfer is taken while
// the output stalls; only the wrap-up of that next one waits for the slot.
`default_nettype none

module sorted_time_table_floor_lookup_core #(
	parameter int TABLE_DEPTH = stfl_pkg::DEF_TABLE_DEPTH,
	parameter int TAG_BITS    = stfl_pkg::DEF_TAG_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [11:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	input  logic [5:0]  second,
	input  logic [15:0] entry_tag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] match_tag,
	output logic [7:0]  entry_count
);

	localparam int KB = stfl_pkg::KEY_BITS;
	localparam int EW = KB + TAG_BITS;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int OTB = stfl_pkg::OUT_TAG_BITS;
	localparam int OCB = stfl_pkg::OUT_COUNT_BITS;

	// table memory: key above tag
	logic [EW-1:0] mem_q [TABLE_DEPTH];
	logic [EW-1:0] rdata_q;

	stfl_pkg::stfl_state_t  state_q, state_d;
	stfl_pkg::stfl_op_t     op_q;
	stfl_pkg::stfl_status_t res_status_q, out_status_q, fin_status;
	logic [TAG_BITS-1:0]    tag_in_q, res_tag_q, out_tag_q, fin_tag;
	logic [CW-1:0]          cnt_q, out_cnt_q, fin_cnt, rd_cnt_q, rd_cnt_m1;
	logic [AW-1:0]          chk_q, rd_addr, mem_waddr;
	logic                   pend_q;
	logic                   out_valid_q;

	logic                   accept;
	logic                   kf_start, kf_done;
	logic [KB-1:0]          kf_key;
	stfl_pkg::stfl_time_t   tm_in;
	logic [TAG_BITS+15:0]   tag_in_ext;
	logic [TAG_BITS+OTB-1:0] tag_out_ext;
	logic [CW+OCB-1:0]      cnt_out_ext;

	logic                   mem_we;
	logic [EW-1:0]          mem_wdata, new_entry;
	logic                   hit, full;
	logic                   scan_init, issue, fin_ld, out_ld;

	assign tm_in = '{year: year, month: month, day: day,
		hour: hour, minute: minute, second: second};
	assign tag_in_ext = {{TAG_BITS{1'b0}}, entry_tag};
	assign accept     = in_valid && !in_stall;

	stfl_key_form u_key_form (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (kf_start),
		.tm     (tm_in),
		.done   (kf_done),
		.key    (kf_key)
	);

	assign new_entry = {kf_key, tag_in_q};
	assign rd_cnt_m1 = rd_cnt_q - CW'(1);
	assign rd_addr   = rd_cnt_m1[AW-1:0];
	assign hit       = pend_q && (rdata_q[EW-1:TAG_BITS] <= kf_key);
	assign full      = (cnt_q == CW'(TABLE_DEPTH));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stfl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory writes and result selection
	always_comb begin
		state_d    = state_q;
		in_stall   = (state_q != stfl_pkg::ST_IDLE);
		kf_start   = 1'b0;
		scan_init  = 1'b0;
		issue      = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = chk_q + AW'(1);
		mem_wdata  = rdata_q;
		fin_ld     = 1'b0;
		fin_status = stfl_pkg::STS_OK;
		fin_tag    = '0;
		fin_cnt    = cnt_q;
		out_ld     = 1'b0;
		unique case (state_q)
			stfl_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (stfl_pkg::stfl_op_t'(opcode))
						stfl_pkg::OP_INSERT: begin
							if (full) begin
								fin_ld     = 1'b1;
								fin_status = stfl_pkg::STS_FULL;
								state_d    = stfl_pkg::ST_FIN;
							end else begin
								kf_start = 1'b1;
								state_d  = stfl_pkg::ST_KEY;
							end
						end
						stfl_pkg::OP_FIND: begin
							kf_start = 1'b1;
							state_d  = stfl_pkg::ST_KEY;
						end
						stfl_pkg::OP_CLEAR: begin
							fin_ld  = 1'b1;
							fin_cnt = '0;
							state_d = stfl_pkg::ST_FIN;
						end
						stfl_pkg::OP_NOP: begin
							fin_ld  = 1'b1;
							state_d = stfl_pkg::ST_FIN;
						end
					endcase
				end
			end
			stfl_pkg::ST_KEY: begin
				if (kf_done) begin
					if (cnt_q != '0) begin
						scan_init = 1'b1;
						state_d   = stfl_pkg::ST_SCAN;
					end else if (op_q == stfl_pkg::OP_INSERT) begin
						state_d = stfl_pkg::ST_HEAD;
					end else begin
						fin_ld     = 1'b1;
						fin_status = stfl_pkg::STS_NOT_FOUND;
						state_d    = stfl_pkg::ST_FIN;
					end
				end
			end
			stfl_pkg::ST_SCAN: begin
				// compare the entry that arrived; shift it up on insert
				if (pend_q) begin
					if (op_q == stfl_pkg::OP_INSERT) begin
						mem_we = 1'b1;
						if (hit) begin
							mem_wdata = new_entry;
							fin_ld    = 1'b1;
							fin_cnt   = cnt_q + CW'(1);
							state_d   = stfl_pkg::ST_FIN;
						end else if (chk_q == '0) begin
							state_d = stfl_pkg::ST_HEAD;
						end
					end else if (hit) begin
						fin_ld  = 1'b1;
						fin_tag = rdata_q[TAG_BITS-1:0];
						state_d = stfl_pkg::ST_FIN;
					end else if (chk_q == '0) begin
						fin_ld     = 1'b1;
						fin_status = stfl_pkg::STS_NOT_FOUND;
						state_d    = stfl_pkg::ST_FIN;
					end
				end
				// next read walks one entry further down
				if (state_d == stfl_pkg::ST_SCAN && rd_cnt_q != '0) begin
					issue = 1'b1;
				end
			end
			stfl_pkg::ST_HEAD: begin
				// new entry goes to the bottom of the table
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = new_entry;
				fin_ld    = 1'b1;
				fin_cnt   = cnt_q + CW'(1);
				state_d   = stfl_pkg::ST_FIN;
			end
			stfl_pkg::ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					out_ld  = 1'b1;
					state_d = stfl_pkg::ST_IDLE;
				end
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_ld) begin
				cnt_q <= fin_cnt;
			end
			if (scan_init) begin
				pend_q <= 1'b0;
			end else begin
				pend_q <= issue;
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// transfer payload, scan pointers and results
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= stfl_pkg::stfl_op_t'(opcode);
			tag_in_q <= tag_in_ext[TAG_BITS-1:0];
		end
		if (scan_init) begin
			rd_cnt_q <= cnt_q;
		end else if (issue) begin
			rd_cnt_q <= rd_cnt_m1;
			chk_q    <= rd_addr;
		end
		if (fin_ld) begin
			res_status_q <= fin_status;
			res_tag_q    <= fin_tag;
		end
		if (out_ld) begin
			out_status_q <= res_status_q;
			out_tag_q    <= res_tag_q;
			out_cnt_q    <= cnt_q;
		end
	end

	// table memory, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem_q[rd_addr];
	end

	assign tag_out_ext = {{OTB{1'b0}}, out_tag_q};
	assign cnt_out_ext = {{OCB{1'b0}}, out_cnt_q};

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign match_tag   = tag_out_ext[OTB-1:0];
	assign entry_count = cnt_out_ext[OCB-1:0];

endmodule

`default_nettype wire

// File: sim/tb.sv
// self-checking testbench for sorted_time_table_floor_lookup_core
// depends on stfl_pkg and the core; keeps its own copy of the sorted table to
// predict status, match tag and entry count of every transfer

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stfl_pkg::*;

	localparam int     TABLE_DEPTH = DEF_TABLE_DEPTH;
	localparam longint KEY_LIMIT   = (longint'(1) << KEY_BITS) - 1;
	localparam int     HOLD_CYCLES = 400;
	localparam int     TAIL_CYCLES = 200;
	localparam int     RECENT_KEEP = 32;

	typedef struct packed {
		stfl_status_t status;
		logic [15:0]  tag;
		logic [7:0]   count;
	} outcome_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic [1:0]  opcode      = OP_NOP;
	logic [11:0] year        = '0;
	logic [3:0]  month       = '0;
	logic [4:0]  day         = '0;
	logic [4:0]  hour        = '0;
	logic [5:0]  minute      = '0;
	logic [5:0]  second      = '0;
	logic [15:0] entry_tag   = '0;
	logic        out_stall   = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [1:0]  status;
	logic [15:0] match_tag;
	logic [7:0]  entry_count;

	// idling control
	logic        idle_en     = 1'b1;
	logic        hold_go     = 1'b0;
	logic        hold_active = 1'b0;
	int unsigned stall_left  = 0;

	// predictor state: table in key order, oldest-first predictions
	logic [KEY_BITS-1:0] held_keys[$];
	logic [15:0]         held_tags[$];
	outcome_t            pending_outcomes[$];
	stfl_time_t          recent_times[$];
	int                  mismatches = 0;

	sorted_time_table_floor_lookup_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.year        (year),
		.month       (month),
		.day         (day),
		.hour        (hour),
		.minute      (minute),
		.second      (second),
		.entry_tag   (entry_tag),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.match_tag   (match_tag),
		.entry_count (entry_count)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mixed-radix time key, saturated into the key range
	function automatic logic [KEY_BITS-1:0] time_key(input stfl_time_t t);
		longint k;
		k = (longint'(t.year) - YEAR_BASE) * DAY_RADIX + (longint'(t.month) - 1);
		k = k * MONTH_RADIX + longint'(t.day);
		k = k * HOUR_RADIX + longint'(t.hour);
		k = k * MINUTE_RADIX + longint'(t.minute);
		k = k * SECOND_RADIX + longint'(t.second);
		if (k < 0)
			k = 0;
		if (k > KEY_LIMIT)
			k = KEY_LIMIT;
		return k[KEY_BITS-1:0];
	endfunction

	// apply one operation to the table copy and give the result it yields
	function automatic outcome_t table_outcome(input stfl_op_t op, input stfl_time_t t,
			input logic [15:0] tag);
		outcome_t            o;
		logic [KEY_BITS-1:0] k;
		int                  pos;
		k = time_key(t);
		o.status = STS_OK;
		o.tag = '0;
		pos = 0;
		case (op)
			OP_INSERT: begin
				if (held_keys.size() >= TABLE_DEPTH) begin
					o.status = STS_FULL;
				end else begin
					// equal keys go after the ones already held
					while (pos < held_keys.size() && held_keys[pos] <= k)
						pos++;
					held_keys.insert(pos, k);
					held_tags.insert(pos, tag);
				end
			end
			OP_FIND: begin
				while (pos < held_keys.size() && held_keys[pos] <= k)
					pos++;
				if (pos == 0)
					o.status = STS_NOT_FOUND;
				else
					o.tag = held_tags[pos-1];
			end
			OP_CLEAR: begin
				held_keys.delete();
				held_tags.delete();
			end
			default: ;
		endcase
		o.count = 8'(held_keys.size());
		return o;
	endfunction

	function automatic stfl_time_t stamp(input int y, input int mo, input int d, input int h,
			input int mi, input int s);
		stfl_time_t t;
		t.year = 12'(y);
		t.month = 4'(mo);
		t.day = 5'(d);
		t.hour = 5'(h);
		t.minute = 6'(mi);
		t.second = 6'(s);
		return t;
	endfunction

	// clustered times give equal keys, wide ones spread out, noise hits odd fields
	function automatic stfl_time_t random_time();
		logic [63:0] raw;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		raw = {$urandom, $urandom};
		if (pick < 5)
			return stamp($urandom_range(2000, 2001), $urandom_range(1, 2), $urandom_range(1, 3),
				$urandom_range(0, 1), $urandom_range(0, 2), $urandom_range(0, 1));
		else if (pick < 9)
			return stamp($urandom_range(1900, 2155), $urandom_range(1, 12), $urandom_range(1, 31),
				$urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
		return raw[$bits(stfl_time_t)-1:0];
	endfunction

	// offer one transfer, wait for it to be taken, then predict its result
	task automatic send_item(input stfl_op_t op, input stfl_time_t t, input logic [15:0] tag);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		opcode    <= op;
		year      <= t.year;
		month     <= t.month;
		day       <= t.day;
		hour      <= t.hour;
		minute    <= t.minute;
		second    <= t.second;
		entry_tag <= tag;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_outcomes.push_back(table_outcome(op, t, tag));
	endtask

	// random operation; clear_pm is the chance of a clear per thousand
	task automatic send_random(input int unsigned clear_pm);
		stfl_op_t    op;
		stfl_time_t  t;
		int unsigned r;
		r = $urandom_range(0, 999);
		if (r < clear_pm)
			op = OP_CLEAR;
		else if (r < clear_pm + 25)
			op = OP_NOP;
		else if (r < 540)
			op = OP_INSERT;
		else
			op = OP_FIND;
		t = random_time();
		// finds often ask for a time that was inserted
		if (op == OP_FIND && recent_times.size() != 0 && $urandom_range(0, 2) == 0)
			t = recent_times[$urandom_range(0, recent_times.size() - 1)];
		if (op == OP_INSERT) begin
			recent_times.push_back(t);
			if (recent_times.size() > RECENT_KEEP)
				void'(recent_times.pop_front());
		end
		send_item(op, t, 16'($urandom_range(0, 65535)));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// extremes, equal keys, early and empty finds, clear and no-op
	task automatic test_directed();
		send_item(OP_FIND, stamp(2000, 1, 1, 0, 0, 0), 16'h1234);
		send_item(OP_CLEAR, stamp(0, 0, 0, 0, 0, 0), 16'h0);
		send_item(OP_NOP, stamp(4095, 15, 31, 31, 63, 63), 16'hFFFF);
		send_item(OP_INSERT, stamp(1900, 1, 0, 0, 0, 0), 16'hFFFF);
		send_item(OP_INSERT, stamp(0, 0, 0, 0, 0, 0), 16'h0000);
		send_item(OP_FIND, stamp(1900, 1, 0, 0, 0, 0), 16'h0);
		send_item(OP_INSERT, stamp(4095, 15, 31, 31, 63, 63), 16'hA5A5);
		send_item(OP_INSERT, stamp(2155, 12, 31, 23, 59, 59), 16'h5A5A);
		send_item(OP_FIND, stamp(2155, 12, 31, 23, 59, 58), 16'h0);
		send_item(OP_FIND, stamp(2155, 12, 31, 23, 59, 59), 16'h0);
		send_item(OP_FIND, stamp(4095, 15, 31, 31, 63, 63), 16'h0);
		send_item(OP_INSERT, stamp(2000, 6, 15, 12, 30, 30), 16'h0001);
		send_item(OP_INSERT, stamp(2000, 6, 15, 12, 30, 30), 16'h0002);
		send_item(OP_FIND, stamp(2000, 6, 15, 12, 30, 30), 16'h0);
		send_item(OP_FIND, stamp(2000, 6, 15, 12, 30, 29), 16'h0);
		send_item(OP_CLEAR, stamp(1900, 1, 1, 0, 0, 0), 16'h0);
		send_item(OP_FIND, stamp(4095, 15, 31, 31, 63, 63), 16'h0);
		send_item(OP_INSERT, stamp(2010, 3, 4, 5, 6, 7), 16'h0003);
		send_item(OP_FIND, stamp(2000, 3, 4, 5, 6, 7), 16'h0);
		send_item(OP_NOP, stamp(2010, 3, 4, 5, 6, 7), 16'hBEEF);
		send_item(OP_FIND, stamp(2010, 3, 4, 5, 6, 8), 16'h0);
	endtask

	// fill the table to the top, then inserts are refused
	task automatic test_full_table();
		send_item(OP_CLEAR, random_time(), 16'h0);
		repeat (TABLE_DEPTH)
			send_item(OP_INSERT, random_time(), 16'($urandom_range(0, 65535)));
		repeat (3)
			send_item(OP_FIND, random_time(), 16'h0);
		repeat (3)
			send_item(OP_INSERT, random_time(), 16'($urandom_range(0, 65535)));
		send_item(OP_NOP, random_time(), 16'h0);
		send_item(OP_FIND, stamp(4095, 15, 31, 31, 63, 63), 16'h0);
		send_item(OP_CLEAR, random_time(), 16'h0);
	endtask

	// receiver holds off for a long stretch while transfers keep coming
	task automatic test_backpressure();
		hold_go <= 1'b1;
		repeat (40)
			send_random(20);
		drain_results();
	endtask

	// random operations at falling clear rates, so the table grows deeper
	task automatic test_random_mix();
		repeat (500)
			send_random(50);
		repeat (450)
			send_random(12);
		repeat (450)
			send_random(2);
	endtask

	// last part with no idling on either side
	task automatic test_no_idle();
		idle_en <= 1'b0;
		repeat (120)
			send_random(15);
	endtask

	// random stall bursts on the result side, or a long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_left <= 0;
			out_stall <= 1'b0;
		end else if (hold_active) begin
			out_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (idle_en && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// long hold-off, counted in cycles
	initial begin
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go <= 1'b0;
				hold_active <= 1'b1;
				repeat (HOLD_CYCLES)
					@(posedge clk);
				hold_active <= 1'b0;
			end
		end
	end

	// compare each result transfer with the oldest prediction
	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t ns: result with none expected: status %0d tag %0h count %0d",
					$time, status, match_tag, entry_count);
				mismatches++;
			end else begin
				want = pending_outcomes.pop_front();
				if (status !== want.status) begin
					$display("%0t ns: status expected %0d, got %0d", $time, want.status, status);
					mismatches++;
				end
				if (match_tag !== want.tag) begin
					$display("%0t ns: match_tag expected %0h, got %0h", $time, want.tag,
						match_tag);
					mismatches++;
				end
				if (entry_count !== want.count) begin
					$display("%0t ns: entry_count expected %0d, got %0d", $time, want.count,
						entry_count);
					mismatches++;
				end
			end
		end
	end

	// test sequence
	initial begin
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_table();
		test_backpressure();
		test_random_mix();
		test_no_idle();
		drain_results();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
